// ===== hdl/mclf_pkg.sv =====
// Package with the shared types and constants of the multi-channel linear fader.
`timescale 1ns / 1ps

package mclf_pkg;

  localparam int CHANNELS_DEF = 64;
  localparam int CHAN_LIMIT   = 64;

  localparam int LEVEL_W = 8;
  localparam int TICKS_W = 13;
  localparam int COUNT_W = 7;
  localparam int PROD_W  = LEVEL_W + TICKS_W;

  // Division of the fade time by ten as a multiply by a reciprocal and a shift.
  localparam logic [16:0] TICK_RECIP = 17'd52429;
  localparam int          TICK_SHIFT = 19;

  localparam int PADDR_W = 3;
  localparam logic        REG_ACTIVE = 1'b0;

  typedef enum logic [1:0] {
    OP_FADE = 2'd0,
    OP_DATA = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic {
    KIND_LEVEL  = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_D_RD,
    ST_D_EXE,
    ST_D_STAT,
    ST_T_RD,
    ST_T_EXE,
    ST_T_DIV,
    ST_T_PUT,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [5:0]  start_channel;
    logic [6:0]  count;
    logic [15:0] fade_time_ms;
    logic [7:0]  data_byte;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [5:0]  channel;
    logic [7:0]  level;
    logic        done_res;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] cur;
    logic [LEVEL_W-1:0] tgt;
    logic [TICKS_W-1:0] tot;
    logic [TICKS_W-1:0] step;
  } chan_rec_t;

endpackage

// ===== hdl/multi_channel_linear_fader_top.sv =====
// Multi-channel linear fader: command decode, channel record memory and shared serial divider.
// A fade command never holds the input. A data word holds it through the flush state alone
// when no command bytes remain or the command was rejected, else through the read, execute,
// status and flush states. A tick with no active channels does not hold it; else each channel
// passes the read and execute states, one mid-fade also the shared restoring divider (one
// quotient bit a cycle over a 21-bit product) and put state. Output stalls can lengthen these.
// Reset clears the command state, the channel count and the per-channel valid bits,
// so every channel reads as level zero with no fade; there is no clearing pass.
`timescale 1ns / 1ps

module multi_channel_linear_fader_top
  import mclf_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_word_t           in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output out_word_t          out_word,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int DEPTH = (CHANNELS < CHAN_LIMIT) ? CHANNELS : CHAN_LIMIT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(PROD_W);
  localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(DEPTH);
  localparam logic [CNT_W-1:0]   DIV_LAST = CNT_W'(PROD_W - 1);

  state_t              state_r, state_nxt;
  logic [COUNT_W-1:0]  active_r, active_nxt;
  logic [TICKS_W-1:0]  cmd_ticks_r, cmd_ticks_nxt;
  logic [COUNT_W-1:0]  cmd_rem_r, cmd_rem_nxt;
  logic [COUNT_W-1:0]  cmd_pos_r, cmd_pos_nxt;
  logic                cmd_err_r, cmd_err_nxt;
  logic [AW-1:0]       ch_r, ch_nxt;
  logic [LEVEL_W-1:0]  d_r, d_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [TICKS_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                up_r, up_nxt;
  logic                pend_v_r, pend_v_nxt;
  out_word_t           pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_word_t           out_r, out_nxt;

  chan_rec_t           mem [DEPTH];
  logic [DEPTH-1:0]    vld_r;
  chan_rec_t           rec_q;
  logic                vld_q;
  logic                we;
  chan_rec_t           wrec;

  logic                cfg_wr;
  logic [COUNT_W-1:0]  eff;
  logic [7:0]          cmd_end;
  logic [32:0]         ms_prod;
  logic [LEVEL_W-1:0]  cur;
  logic [TICKS_W-1:0]  tot;
  logic [LEVEL_W-1:0]  held;
  logic [LEVEL_W-1:0]  diff;
  logic [TICKS_W:0]    rem_sh;
  logic                div_ge;
  logic [LEVEL_W-1:0]  part;
  logic [LEVEL_W-1:0]  tick_lvl;
  logic                ch_is_last;
  logic                out_free;
  logic                can_put;
  logic                put_en;
  out_word_t           put_word;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign prdata   = (paddr[PADDR_W-1] == REG_ACTIVE) ? {25'd0, active_r} : 32'd0;

  assign eff      = (active_r > DEPTH_C) ? DEPTH_C : active_r;
  assign cmd_end  = {2'b00, in_word.start_channel} + {1'b0, in_word.count};
  assign ms_prod  = 33'(in_word.fade_time_ms) * 33'(TICK_RECIP);

  assign cur      = vld_q ? rec_q.cur : '0;
  assign tot      = vld_q ? rec_q.tot : '0;
  assign held     = (tot != '0) ? rec_q.tgt : cur;
  assign diff     = (rec_q.tgt > cur) ? rec_q.tgt - cur : cur - rec_q.tgt;
  assign rem_sh   = {rem_r, prod_r[PROD_W-1]};
  assign div_ge   = rem_sh >= {1'b0, tot};
  assign part     = prod_r[LEVEL_W-1:0];
  assign tick_lvl = up_r ? cur + part : cur - part;
  assign ch_is_last = (COUNT_W'(ch_r) + COUNT_W'(1)) >= eff;

  assign out_free = !out_valid_r || !out_stall;
  assign can_put  = !pend_v_r || out_free;
  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[ch_r] <= wrec;
    end
    rec_q <= mem[ch_r];
    vld_q <= vld_r[ch_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[ch_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= '0;
      cmd_ticks_r <= '0;
      cmd_rem_r   <= '0;
      cmd_pos_r   <= '0;
      cmd_err_r   <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      cmd_ticks_r <= cmd_ticks_nxt;
      cmd_rem_r   <= cmd_rem_nxt;
      cmd_pos_r   <= cmd_pos_nxt;
      cmd_err_r   <= cmd_err_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r   <= ch_nxt;
    d_r    <= d_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    up_r   <= up_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    active_nxt    = active_r;
    cmd_ticks_nxt = cmd_ticks_r;
    cmd_rem_nxt   = cmd_rem_r;
    cmd_pos_nxt   = cmd_pos_r;
    cmd_err_nxt   = cmd_err_r;
    ch_nxt        = ch_r;
    d_nxt         = d_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    up_nxt        = up_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    we            = 1'b0;
    wrec          = rec_q;
    wrec.cur      = cur;
    wrec.tot      = tot;
    put_en        = 1'b0;
    put_word      = '{kind: KIND_STATUS, channel: '0, level: '0, done_res: 1'b0, last: 1'b0};

    if (cfg_wr && paddr[PADDR_W-1] == REG_ACTIVE) begin
      active_nxt = pwdata[COUNT_W-1:0];
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_word.operation)
            OP_FADE: begin
              cmd_rem_nxt   = in_word.count;
              cmd_pos_nxt   = {1'b0, in_word.start_channel};
              cmd_err_nxt   = 1'b1;
              cmd_ticks_nxt = '0;
              if (cmd_end <= {1'b0, eff}) begin
                cmd_err_nxt   = 1'b0;
                cmd_ticks_nxt = ms_prod[TICK_SHIFT +: TICKS_W];
              end
            end
            OP_DATA: begin
              d_nxt = in_word.data_byte;
              if (cmd_rem_r == '0) begin
                put_en            = 1'b1;
                put_word.done_res = 1'b1;
                state_nxt         = ST_FLUSH;
              end else begin
                cmd_rem_nxt = cmd_rem_r - COUNT_W'(1);
                if (!cmd_err_r && cmd_pos_r < DEPTH_C) begin
                  ch_nxt      = cmd_pos_r[AW-1:0];
                  cmd_pos_nxt = cmd_pos_r + COUNT_W'(1);
                  state_nxt   = ST_D_RD;
                end else begin
                  put_en    = 1'b1;
                  state_nxt = ST_FLUSH;
                end
              end
            end
            OP_TICK: begin
              if (eff != '0) begin
                ch_nxt    = '0;
                state_nxt = ST_T_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_D_RD: begin
        state_nxt = ST_D_EXE;
      end
      ST_D_EXE: begin
        if (can_put) begin
          we               = 1'b1;
          put_word.kind    = KIND_LEVEL;
          put_word.channel = 6'(ch_r);
          state_nxt        = ST_D_STAT;
          if (cmd_ticks_r == '0) begin
            wrec.cur       = d_r;
            wrec.tot       = '0;
            put_en         = 1'b1;
            put_word.level = d_r;
          end else begin
            wrec.cur       = held;
            put_en         = (tot != '0);
            put_word.level = held;
            if (held == d_r) begin
              wrec.tot = '0;
            end else begin
              wrec.tot  = cmd_ticks_r;
              wrec.step = '0;
              wrec.tgt  = d_r;
            end
          end
        end
      end
      ST_D_STAT: begin
        if (can_put) begin
          put_en    = 1'b1;
          state_nxt = ST_FLUSH;
        end
      end
      ST_T_RD: begin
        state_nxt = ST_T_EXE;
      end
      ST_T_EXE: begin
        if (tot == '0) begin
          if (ch_is_last) begin
            state_nxt = ST_FLUSH;
          end else begin
            ch_nxt    = ch_r + AW'(1);
            state_nxt = ST_T_RD;
          end
        end else if (rec_q.step >= tot) begin
          if (can_put) begin
            we               = 1'b1;
            wrec.cur         = rec_q.tgt;
            wrec.tot         = '0;
            put_en           = 1'b1;
            put_word.kind    = KIND_LEVEL;
            put_word.channel = 6'(ch_r);
            put_word.level   = rec_q.tgt;
            if (ch_is_last) begin
              state_nxt = ST_FLUSH;
            end else begin
              ch_nxt    = ch_r + AW'(1);
              state_nxt = ST_T_RD;
            end
          end
        end else begin
          prod_nxt  = PROD_W'(diff) * PROD_W'(rec_q.step);
          up_nxt    = rec_q.tgt > cur;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_T_DIV;
        end
      end
      ST_T_DIV: begin
        rem_nxt  = div_ge ? TICKS_W'(rem_sh - {1'b0, tot}) : rem_sh[TICKS_W-1:0];
        prod_nxt = {prod_r[PROD_W-2:0], div_ge};
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_T_PUT;
        end
      end
      ST_T_PUT: begin
        if (can_put) begin
          we               = 1'b1;
          wrec.step        = rec_q.step + TICKS_W'(1);
          put_en           = 1'b1;
          put_word.kind    = KIND_LEVEL;
          put_word.channel = 6'(ch_r);
          put_word.level   = tick_lvl;
          if (ch_is_last) begin
            state_nxt = ST_FLUSH;
          end else begin
            ch_nxt    = ch_r + AW'(1);
            state_nxt = ST_T_RD;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_nxt       = pend_r;
          out_nxt.last  = 1'b1;
          out_valid_nxt = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (put_en) begin
      if (pend_v_r) begin
        out_nxt       = pend_r;
        out_valid_nxt = 1'b1;
      end
      pend_nxt   = put_word;
      pend_v_nxt = 1'b1;
    end
  end

endmodule

// ===== test/tb_multi_channel_linear_fader_top.sv =====
// Self-checking testbench for the multi-channel linear fader top level.
`timescale 1ns / 1ps

module tb_multi_channel_linear_fader_top
  import mclf_pkg::*;
();

  localparam int NCH          = 64;
  localparam int TICK_MS      = 10;
  localparam int HOLD_CYCLES  = 3000;
  localparam int DRAIN_CYCLES = 2000;
  localparam int TIMEOUT_NS   = 200_000_000;

  class level_scoreboard;
    bit [7:0]  level_now [NCH];
    bit [7:0]  level_goal [NCH];
    bit [12:0] fade_len [NCH];
    bit [12:0] fade_pos [NCH];
    bit [12:0] cmd_len;
    bit [6:0]  bytes_left;
    int        next_chan;
    bit        rejected;
    bit [6:0]  chan_reg;
    out_word_t due_words[$];

    function new();
      for (int c = 0; c < NCH; c++) begin
        level_now[c] = '0;
        level_goal[c] = '0;
        fade_len[c] = '0;
        fade_pos[c] = '0;
      end
      cmd_len = '0;
      bytes_left = '0;
      next_chan = 0;
      rejected = 1'b0;
      chan_reg = '0;
    endfunction

    function void set_channels(bit [6:0] value);
      chan_reg = value;
    endfunction

    function int outstanding();
      return due_words.size();
    endfunction

    function void push_res(kind_t k, int ch, int lvl, bit done);
      out_word_t r;
      r.kind = k;
      r.channel = 6'(ch);
      r.level = 8'(lvl);
      r.done_res = done;
      r.last = 1'b0;
      due_words.push_back(r);
    endfunction

    function void note_word(in_word_t w);
      int        base;
      int        lim;
      int        c;
      int        t;
      int        s;
      int        diff;
      int        part;
      bit [7:0]  d;
      bit [7:0]  held;
      out_word_t r;
      base = due_words.size();
      lim = (chan_reg > 7'd64) ? 64 : int'(chan_reg);
      case (w.operation)
        OP_FADE: begin
          bytes_left = w.count;
          next_chan = int'(w.start_channel);
          rejected = 1'b1;
          cmd_len = '0;
          if (int'(w.start_channel) + int'(w.count) <= lim) begin
            cmd_len = 13'(int'(w.fade_time_ms) / TICK_MS);
            rejected = 1'b0;
          end
        end
        OP_DATA: begin
          if (bytes_left == 0) begin
            push_res(KIND_STATUS, 0, 0, 1'b1);
          end else begin
            bytes_left = bytes_left - 7'd1;
            if (!rejected && next_chan < NCH) begin
              c = next_chan;
              d = w.data_byte;
              if (cmd_len == 0) begin
                level_now[c] = d;
                fade_len[c] = '0;
                push_res(KIND_LEVEL, c, int'(d), 1'b0);
              end else begin
                if (fade_len[c] != 0) begin
                  held = level_goal[c];
                  level_now[c] = held;
                  push_res(KIND_LEVEL, c, int'(held), 1'b0);
                end else begin
                  held = level_now[c];
                end
                if (held == d) begin
                  fade_len[c] = '0;
                end else begin
                  fade_len[c] = cmd_len;
                  fade_pos[c] = '0;
                  level_goal[c] = d;
                end
              end
              next_chan++;
            end
            push_res(KIND_STATUS, 0, 0, 1'b0);
          end
        end
        OP_TICK: begin
          for (c = 0; c < lim; c++) begin
            if (fade_len[c] != 0) begin
              if (fade_pos[c] >= fade_len[c]) begin
                level_now[c] = level_goal[c];
                fade_len[c] = '0;
                push_res(KIND_LEVEL, c, int'(level_goal[c]), 1'b0);
              end else begin
                t = int'(level_goal[c]);
                s = int'(level_now[c]);
                diff = (t > s) ? t - s : s - t;
                part = (diff * int'(fade_pos[c])) / int'(fade_len[c]);
                push_res(KIND_LEVEL, c, (t > s) ? s + part : s - part, 1'b0);
                fade_pos[c] = fade_pos[c] + 13'd1;
              end
            end
          end
        end
        default: ;
      endcase
      if (due_words.size() > base) begin
        r = due_words.pop_back();
        r.last = 1'b1;
        due_words.push_back(r);
      end
    endfunction

    function string check_word(out_word_t got);
      out_word_t want;
      string     msg;
      if (due_words.size() == 0) begin
        return $sformatf("unexpected word kind %0d channel %0d level %0d done %0d last %0d",
                         got.kind, got.channel, got.level, got.done_res, got.last);
      end
      want = due_words.pop_front();
      msg = "";
      if (got.kind !== want.kind)
        msg = {msg, $sformatf(" kind %0d/%0d", got.kind, want.kind)};
      if (got.channel !== want.channel)
        msg = {msg, $sformatf(" channel %0d/%0d", got.channel, want.channel)};
      if (got.level !== want.level)
        msg = {msg, $sformatf(" level %0d/%0d", got.level, want.level)};
      if (got.done_res !== want.done_res)
        msg = {msg, $sformatf(" done %0d/%0d", got.done_res, want.done_res)};
      if (got.last !== want.last)
        msg = {msg, $sformatf(" last %0d/%0d", got.last, want.last)};
      if (msg != "") msg = {"word field(s) got/expected:", msg};
      return msg;
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  in_word_t           in_word;
  logic               out_valid;
  logic               out_stall;
  out_word_t          out_word;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  level_scoreboard sb;
  int              mismatches;
  int              n_active;
  int              burst_left;
  bit              hold_req;

  multi_channel_linear_fader_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  task automatic report_mismatch(string msg);
    if (mismatches < 40) $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(15, 60);
  endfunction

  function automatic logic [15:0] pick_ms();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 16'($urandom_range(0, 9));
    if (r < 90) return 16'($urandom_range(10, 150));
    if (r < 97) return 16'($urandom_range(151, 2000));
    if (r < 98) return 16'hffff;
    return 16'($urandom);
  endfunction

  function automatic logic [7:0] pick_level();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hff;
    return 8'($urandom);
  endfunction

  function automatic in_word_t junk_word(op_t op);
    in_word_t w;
    w.operation = op;
    w.start_channel = 6'($urandom);
    w.count = 7'($urandom);
    w.fade_time_ms = 16'($urandom);
    w.data_byte = 8'($urandom);
    return w;
  endfunction

  always @(posedge clk) begin
    string msg;
    if (rst_n && out_valid && !out_stall) begin
      msg = sb.check_word(out_word);
      if (msg != "") report_mismatch(msg);
    end
  end

  initial begin
    int unsigned run;
    bit          stalled;
    run = 0;
    stalled = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        stalled = 1'b0;
        run = 0;
      end else if (run != 0) begin
        run--;
      end else if (stalled) begin
        stalled = 1'b0;
        out_stall <= 1'b0;
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 12);
      end else begin
        run = pick_gap();
        if (run != 0) begin
          stalled = 1'b1;
          out_stall <= 1'b1;
          run--;
        end else begin
          run = $urandom_range(0, 12);
        end
      end
    end
  end

  task automatic send_word(in_word_t w);
    int unsigned gap;
    if (burst_left != 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 39) == 0) burst_left = $urandom_range(10, 30);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_word <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_word(w);
  endtask

  task automatic send_fade(int start, int cnt, logic [15:0] ms);
    in_word_t w;
    w = junk_word(OP_FADE);
    w.start_channel = 6'(start);
    w.count = 7'(cnt);
    w.fade_time_ms = ms;
    send_word(w);
  endtask

  task automatic send_data(logic [7:0] d);
    in_word_t w;
    w = junk_word(OP_DATA);
    w.data_byte = d;
    send_word(w);
  endtask

  task automatic send_tick();
    send_word(junk_word(OP_TICK));
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_active(int value);
    logic [31:0] rd;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_ACTIVE, 2'b00};
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_channels(7'(value));
    n_active = (value > NCH) ? NCH : value;
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd[6:0] !== 7'(value))
      report_mismatch($sformatf("channel count reads %0d, written %0d", rd[6:0], value));
  endtask

  task automatic run_directed();
    send_data(8'hff);
    send_word('1);
    send_tick();
    send_fade(0, 64, 16'd9);
    send_data(8'hff);
    send_data(8'h00);
    send_fade(63, 1, 16'hffff);
    send_data(8'h80);
    send_data(8'h5a);
    send_fade(63, 2, 16'd100);
    send_data(8'h11);
    send_data(8'h22);
    send_data(8'h33);
    send_fade(0, 3, 16'd30);
    send_data(8'h00);
    send_data(8'h00);
    send_data(8'h40);
    send_tick();
    send_tick();
    send_fade(0, 1, 16'd20);
    send_data(8'h00);
    send_tick();
    send_tick();
    send_tick();
    send_fade(0, 127, 16'd0);
  endtask

  task automatic run_random(int budget);
    int sent;
    int r;
    int start;
    int room;
    int cnt;
    sent = 0;
    while (sent < budget) begin
      r = $urandom_range(0, 99);
      if (r < 70 && n_active > 0) begin
        start = $urandom_range(0, n_active - 1);
        room = n_active - start;
        cnt = ($urandom_range(0, 9) == 0) ? room : $urandom_range(1, (room < 6) ? room : 6);
        send_fade(start, cnt, pick_ms());
        sent++;
        for (int i = 0; i < cnt; i++) begin
          if ($urandom_range(0, 19) == 0) break;
          send_data(pick_level());
          sent++;
          if ($urandom_range(0, 4) == 0) begin
            send_tick();
            sent++;
          end
        end
        cnt = $urandom_range(0, 3);
        for (int i = 0; i < cnt; i++) begin
          send_tick();
          sent++;
        end
      end else if (r < 85) begin
        send_tick();
        sent++;
      end else if (r < 92) begin
        send_fade($urandom_range(0, 63), $urandom_range(0, 127), 16'($urandom));
        sent++;
        cnt = $urandom_range(0, 3);
        for (int i = 0; i < cnt; i++) begin
          send_data(8'($urandom));
          sent++;
        end
      end else if (r < 97) begin
        send_data(8'($urandom));
        sent++;
      end else begin
        send_word(junk_word(OP_NONE));
      end
    end
  endtask

  initial begin
    sb = new();
    mismatches = 0;
    n_active = 0;
    burst_left = 0;
    hold_req = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_word <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_active(127);
    run_directed();
    drain_block();

    write_active(64);
    hold_req = 1'b1;
    run_random(120);
    drain_block();

    write_active(1);
    run_random(40);
    drain_block();

    write_active(0);
    run_random(20);
    drain_block();

    write_active(40);
    run_random(70);
    drain_block();

    write_active($urandom_range(2, 63));
    run_random(60);
    drain_block();

    write_active(64);
    run_random(40);
    drain_block();

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
